// ===== design/wcc_pkg.sv =====
// Shared constants and control/status types for the Ward clustering cut block.
`timescale 1ns / 1ps

package wcc_pkg;

	localparam int MAX_POINTS = 64;
	localparam int FRAC_BITS  = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int DIST_W     = 18;
	localparam int SQ_W       = 32;
	localparam int CUT_W      = 18;
	localparam int ADDR_W     = 2 * IDX_W;
	localparam int PROD_W     = SQ_W + CNT_W;
	localparam int ACC_W      = PROD_W + 2;
	localparam int DIV_W      = ACC_W - 1;
	localparam int DCNT_W     = $clog2(DIV_W + 1);
	localparam int CUT_RESET  = 19661;

	localparam logic [DIST_W-1:0] DIST_CLAMP = DIST_W'(2 << FRAC_BITS);

	// register indexes on the configuration port
	localparam logic REG_CUT_HEIGHT = 1'b0;

	typedef struct packed {
		logic load;
		logic start;
		logic srch_clr;
		logic srch_step;
		logic rd_mi;
		logic rd_mj;
		logic ni_cap;
		logic nj_cap;
		logic k_clr;
		logic k_inc;
		logic upd_a;
		logic upd_b;
		logic upd_c;
		logic upd_d;
		logic div_load;
		logic div_step;
		logic upd_wr;
		logic merge;
		logic ren_clr;
		logic ren_step;
		logic out_adv;
	} cmd_t;

	typedef struct packed {
		logic func;
		logic cnt_zero;
		logic cnt_one;
		logic srch_last;
		logic merge_ok;
		logic k_skip;
		logic k_last;
		logic div_last;
		logic ren_last;
		logic out_last;
	} sts_t;

endpackage

// ===== design/wcc_req_if.sv =====
// Request channel: load and start items.
`timescale 1ns / 1ps

interface wcc_req_if;
	logic                             valid;
	logic                             ready;
	logic                             func;
	logic [wcc_pkg::IDX_W-1:0]        row_index;
	logic [wcc_pkg::IDX_W-1:0]        col_index;
	logic [wcc_pkg::DIST_W-1:0]       distance;
	logic [wcc_pkg::CNT_W-1:0]        point_count;

	modport source (output valid, func, row_index, col_index, distance, point_count,
		input ready);
	modport sink (input valid, func, row_index, col_index, distance, point_count,
		output ready);
endinterface

// ===== design/wcc_rsp_if.sv =====
// Result channel: one cluster assignment per point.
`timescale 1ns / 1ps

interface wcc_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [wcc_pkg::IDX_W-1:0]        point_index;
	logic [wcc_pkg::IDX_W-1:0]        cluster_id;
	logic [wcc_pkg::CNT_W-1:0]        cluster_count;
	logic                             last_point;

	modport source (output valid, point_index, cluster_id, cluster_count, last_point,
		input ready);
	modport sink (input valid, point_index, cluster_id, cluster_count, last_point,
		output ready);
endinterface

// ===== design/wcc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wcc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/wcc_ctrl.sv =====
// Sequencer for load, merge search, Ward update, renumbering and result output.
`timescale 1ns / 1ps

module wcc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  wcc_pkg::sts_t sts,
	output wcc_pkg::cmd_t cmd
);

	typedef enum logic [15:0] {
		S_IDLE    = 16'h0001,
		S_SRCH    = 16'h0002,
		S_SDRAIN  = 16'h0004,
		S_DECIDE  = 16'h0008,
		S_LD_NI   = 16'h0010,
		S_LD_NJ   = 16'h0020,
		S_UPD_A   = 16'h0040,
		S_UPD_B   = 16'h0080,
		S_UPD_C   = 16'h0100,
		S_UPD_D   = 16'h0200,
		S_UPD_E   = 16'h0400,
		S_UPD_DIV = 16'h0800,
		S_UPD_WR  = 16'h1000,
		S_MERGE   = 16'h2000,
		S_RENUM   = 16'h4000,
		S_OUT     = 16'h8000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		req_ready = (state_q == S_IDLE);
		rsp_valid = (state_q == S_OUT);
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (!sts.func) begin
						cmd.load = 1'b1;
					end else if (!sts.cnt_zero) begin
						cmd.start = 1'b1;
						if (sts.cnt_one) begin
							cmd.ren_clr = 1'b1;
							state_nxt   = S_RENUM;
						end else begin
							cmd.srch_clr = 1'b1;
							state_nxt    = S_SRCH;
						end
					end
				end
			end
			S_SRCH: begin
				cmd.srch_step = 1'b1;
				if (sts.srch_last) begin
					state_nxt = S_SDRAIN;
				end
			end
			S_SDRAIN: begin
				state_nxt = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.merge_ok) begin
					cmd.rd_mi = 1'b1;
					state_nxt = S_LD_NI;
				end else begin
					cmd.ren_clr = 1'b1;
					state_nxt   = S_RENUM;
				end
			end
			S_LD_NI: begin
				cmd.ni_cap = 1'b1;
				cmd.rd_mj  = 1'b1;
				state_nxt  = S_LD_NJ;
			end
			S_LD_NJ: begin
				cmd.nj_cap = 1'b1;
				cmd.k_clr  = 1'b1;
				state_nxt  = S_UPD_A;
			end
			S_UPD_A: begin
				if (sts.k_skip) begin
					if (sts.k_last) begin
						state_nxt = S_MERGE;
					end else begin
						cmd.k_inc = 1'b1;
					end
				end else begin
					cmd.upd_a = 1'b1;
					state_nxt = S_UPD_B;
				end
			end
			S_UPD_B: begin
				cmd.upd_b = 1'b1;
				state_nxt = S_UPD_C;
			end
			S_UPD_C: begin
				cmd.upd_c = 1'b1;
				state_nxt = S_UPD_D;
			end
			S_UPD_D: begin
				cmd.upd_d = 1'b1;
				state_nxt = S_UPD_E;
			end
			S_UPD_E: begin
				cmd.div_load = 1'b1;
				state_nxt    = S_UPD_DIV;
			end
			S_UPD_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = S_UPD_WR;
				end
			end
			S_UPD_WR: begin
				cmd.upd_wr = 1'b1;
				if (sts.k_last) begin
					state_nxt = S_MERGE;
				end else begin
					cmd.k_inc = 1'b1;
					state_nxt = S_UPD_A;
				end
			end
			S_MERGE: begin
				cmd.merge    = 1'b1;
				cmd.srch_clr = 1'b1;
				state_nxt    = S_SRCH;
			end
			S_RENUM: begin
				cmd.ren_step = 1'b1;
				if (sts.ren_last) begin
					state_nxt = S_OUT;
				end
			end
			S_OUT: begin
				if (rsp_ready) begin
					cmd.out_adv = 1'b1;
					if (sts.out_last) begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	a_stop_renum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && !sts.merge_ok) |=> (state_q == S_RENUM))
		else $error("cut reached but renumbering did not follow");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken while results pending");

	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && rsp_ready && sts.out_last) |=> (state_q == S_IDLE))
		else $error("did not return to idle after final result");

endmodule

// ===== design/wcc_dp.sv =====
// Datapath: distance store, pair search, Ward update with divider, labels and output.
`timescale 1ns / 1ps

module wcc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wcc_pkg::cmd_t                 cmd,
	output wcc_pkg::sts_t                 sts,
	input  logic                          func,
	input  logic [wcc_pkg::IDX_W-1:0]     row_index,
	input  logic [wcc_pkg::IDX_W-1:0]     col_index,
	input  logic [wcc_pkg::DIST_W-1:0]    distance,
	input  logic [wcc_pkg::CNT_W-1:0]     point_count,
	input  logic [wcc_pkg::CUT_W-1:0]     cut_height,
	output logic [wcc_pkg::IDX_W-1:0]     point_index,
	output logic [wcc_pkg::IDX_W-1:0]     cluster_id,
	output logic [wcc_pkg::CNT_W-1:0]     cluster_count,
	output logic                          last_point
);

	localparam int NP  = wcc_pkg::MAX_POINTS;
	localparam int IW  = wcc_pkg::IDX_W;
	localparam int CW  = wcc_pkg::CNT_W;
	localparam int SW  = wcc_pkg::SQ_W;
	localparam int DW  = wcc_pkg::DIST_W;
	localparam int AW  = wcc_pkg::ADDR_W;
	localparam int PW  = wcc_pkg::PROD_W;
	localparam int ACW = wcc_pkg::ACC_W;
	localparam int VW  = wcc_pkg::DIV_W;
	localparam int DCW = wcc_pkg::DCNT_W;

	function automatic logic [SW-1:0] sq_fix(input logic [DW-1:0] v);
		logic [2*DW-1:0] p;
		logic [2*DW-1:0] s;
		p = (2*DW)'(v) * (2*DW)'(v);
		s = p >> wcc_pkg::FRAC_BITS;
		if (|s[2*DW-1:SW]) begin
			sq_fix = '1;
		end else begin
			sq_fix = s[SW-1:0];
		end
	endfunction

	function automatic logic [AW-1:0] canon(input logic [IW-1:0] a, input logic [IW-1:0] b);
		canon = (a < b) ? {a, b} : {b, a};
	endfunction

	// state
	logic [CW-1:0]   n_q;
	logic [SW-1:0]   hsq_q;
	logic [IW-1:0]   i_q, j_q, i_s1, j_s1;
	logic            cmp_v_s1;
	logic            found_q;
	logic [SW-1:0]   best_q;
	logic [IW-1:0]   mi_q, mj_q, k_q, r_q, o_q;
	logic [NP-1:0]   active_q, szv_q;
	logic            szok_q;
	logic [IW-1:0]   labels_q [NP];
	logic [CW-1:0]   ni_q, nj_q, nk_q, cnt_q, dv_q;
	logic [PW-1:0]   prod_q;
	logic [ACW-1:0]  acc_q;
	logic [VW-1:0]   dq_q;
	logic [CW-1:0]   rem_q;
	logic [DCW-1:0]  dcnt_q;

	// memories
	logic            d_we, d_re;
	logic [AW-1:0]   d_waddr, d_raddr;
	logic [SW-1:0]   d_wdata, d_rdata;
	logic            s_we, s_re;
	logic [IW-1:0]   s_raddr;
	logic [CW-1:0]   s_rdata;

	logic [DW-1:0]   dclamp;
	logic [CW-1:0]   pc_sat, size_rd, coef, nsum;
	logic [SW-1:0]   mul_op;
	logic [ACW-1:0]  num;
	logic [CW-1:0]   r2;

	assign dclamp  = (distance > wcc_pkg::DIST_CLAMP) ? wcc_pkg::DIST_CLAMP : distance;
	assign pc_sat  = (point_count > CW'(NP)) ? CW'(NP) : point_count;
	assign size_rd = szok_q ? s_rdata : CW'(1);
	assign nsum    = CW'(nk_q + ni_q + nj_q);
	assign num     = acc_q - ACW'(prod_q);
	assign r2      = {rem_q[CW-2:0], dq_q[VW-1]};

	always_comb begin
		d_we    = cmd.load || cmd.upd_wr;
		d_waddr = cmd.load ? canon(row_index, col_index) : canon(k_q, mi_q);
		if (cmd.load) begin
			d_wdata = sq_fix(dclamp);
		end else if (|dq_q[VW-1:SW]) begin
			d_wdata = '1;
		end else begin
			d_wdata = dq_q[SW-1:0];
		end
		d_re = cmd.srch_step || cmd.upd_a || cmd.upd_b;
		if (cmd.srch_step) begin
			d_raddr = {i_q, j_q};
		end else if (cmd.upd_a) begin
			d_raddr = canon(k_q, mi_q);
		end else begin
			d_raddr = canon(k_q, mj_q);
		end
		s_we = cmd.merge;
		s_re = cmd.rd_mi || cmd.rd_mj || cmd.upd_a;
		if (cmd.rd_mi) begin
			s_raddr = mi_q;
		end else if (cmd.rd_mj) begin
			s_raddr = mj_q;
		end else begin
			s_raddr = k_q;
		end
		if (cmd.upd_b) begin
			coef   = CW'(size_rd + ni_q);
			mul_op = d_rdata;
		end else if (cmd.upd_c) begin
			coef   = CW'(nk_q + nj_q);
			mul_op = d_rdata;
		end else begin
			coef   = nk_q;
			mul_op = best_q;
		end
	end

	wcc_ram #(.WIDTH(SW), .DEPTH(NP * NP)) u_dist_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.re    (d_re),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	wcc_ram #(.WIDTH(CW), .DEPTH(NP)) u_size_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (mi_q),
		.wdata (CW'(ni_q + nj_q)),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= 1'b0;
			cmp_v_s1 <= 1'b0;
			active_q <= '1;
			szv_q    <= '0;
			n_q      <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			r_q      <= '0;
			o_q      <= '0;
			cnt_q    <= '0;
			dcnt_q   <= '0;
		end else begin
			cmp_v_s1 <= cmd.srch_step && active_q[i_q] && active_q[j_q];
			if (cmd.start) begin
				n_q      <= pc_sat;
				active_q <= '1;
				szv_q    <= '0;
			end
			if (cmd.srch_clr) begin
				i_q     <= '0;
				j_q     <= IW'(1);
				found_q <= 1'b0;
			end else if (cmd.srch_step) begin
				if (CW'(j_q) == n_q - CW'(1)) begin
					i_q <= IW'(i_q + 1);
					j_q <= IW'(i_q + 2);
				end else begin
					j_q <= IW'(j_q + 1);
				end
			end
			if (cmp_v_s1 && (!found_q || d_rdata < best_q)) begin
				found_q <= 1'b1;
			end
			if (cmd.k_clr) begin
				k_q <= '0;
			end else if (cmd.k_inc) begin
				k_q <= IW'(k_q + 1);
			end
			if (cmd.div_load) begin
				dcnt_q <= DCW'(VW);
			end else if (cmd.div_step) begin
				dcnt_q <= DCW'(dcnt_q - 1);
			end
			if (cmd.merge) begin
				active_q[mj_q] <= 1'b0;
				szv_q[mi_q]    <= 1'b1;
			end
			if (cmd.ren_clr) begin
				r_q   <= '0;
				o_q   <= '0;
				cnt_q <= '0;
			end else if (cmd.ren_step) begin
				r_q <= IW'(r_q + 1);
				if (active_q[r_q]) begin
					cnt_q <= CW'(cnt_q + 1);
				end
			end else if (cmd.out_adv) begin
				o_q <= IW'(o_q + 1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hsq_q <= sq_fix(cut_height);
		end
		i_s1 <= i_q;
		j_s1 <= j_q;
		if (cmp_v_s1 && (!found_q || d_rdata < best_q)) begin
			best_q <= d_rdata;
			mi_q   <= i_s1;
			mj_q   <= j_s1;
		end
		if (s_re) begin
			szok_q <= szv_q[s_raddr];
		end
		if (cmd.ni_cap) begin
			ni_q <= size_rd;
		end
		if (cmd.nj_cap) begin
			nj_q <= size_rd;
		end
		if (cmd.upd_b) begin
			nk_q <= size_rd;
		end
		if (cmd.upd_b || cmd.upd_c || cmd.upd_d) begin
			prod_q <= PW'(coef * mul_op);
		end
		if (cmd.upd_c) begin
			acc_q <= ACW'(prod_q);
		end else if (cmd.upd_d) begin
			acc_q <= acc_q + ACW'(prod_q);
		end
		if (cmd.div_load) begin
			// a negative numerator always ends at zero
			dq_q  <= num[ACW-1] ? '0 : num[VW-1:0];
			rem_q <= '0;
			dv_q  <= nsum;
		end else if (cmd.div_step) begin
			if (r2 >= dv_q) begin
				rem_q <= r2 - dv_q;
				dq_q  <= {dq_q[VW-2:0], 1'b1};
			end else begin
				rem_q <= r2;
				dq_q  <= {dq_q[VW-2:0], 1'b0};
			end
		end
		for (int p = 0; p < NP; p++) begin
			if (cmd.start) begin
				labels_q[p] <= IW'(p);
			end else if (cmd.merge) begin
				if (labels_q[p] == mj_q) begin
					labels_q[p] <= mi_q;
				end
			end else if (cmd.ren_step) begin
				if (active_q[r_q] && labels_q[p] == r_q) begin
					labels_q[p] <= cnt_q[IW-1:0];
				end
			end else if (cmd.out_adv) begin
				labels_q[p] <= (p == NP - 1) ? '0 : labels_q[(p + 1) % NP];
			end
		end
	end

	always_comb begin
		sts.func      = func;
		sts.cnt_zero  = (point_count == '0);
		sts.cnt_one   = (point_count == CW'(1));
		sts.srch_last = (CW'(i_q) == n_q - CW'(2)) && (CW'(j_q) == n_q - CW'(1));
		sts.merge_ok  = found_q && (best_q <= hsq_q);
		sts.k_skip    = !active_q[k_q] || (k_q == mi_q) || (k_q == mj_q);
		sts.k_last    = (CW'(k_q) == n_q - CW'(1));
		sts.div_last  = (dcnt_q == DCW'(1));
		sts.ren_last  = (CW'(r_q) == n_q - CW'(1));
		sts.out_last  = (CW'(o_q) == n_q - CW'(1));
	end

	assign point_index   = o_q;
	assign cluster_id    = labels_q[0];
	assign cluster_count = cnt_q;
	assign last_point    = sts.out_last;

	a_found_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(found_q) |-> $past(cmp_v_s1))
		else $error("minimum found without a compared pair");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_load |=> (dv_q != '0))
		else $error("Ward divisor is zero");

endmodule

// ===== design/ward_clustering_cut.sv =====
// Top level of the Ward clustering cut block: APB register, controller and datapath.
// A load request is taken while idle, one per cycle back to back.
// A start request runs merge passes: each scans n*(n-1)/2 pairs at one store read per cycle,
// then updates every other active cluster through the one-bit-per-cycle divider and skips
// the rest; the pass that meets the cut stops, and renumbering follows.
// Results follow one per cycle when taken; no new request is taken until the last goes.
// Reset: arst_n clears control state, cut_height returns to 19661; the store is not cleared.
`timescale 1ns / 1ps

module ward_clustering_cut (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	wcc_req_if.sink      req,
	wcc_rsp_if.source    rsp
);

	logic [wcc_pkg::CUT_W-1:0] cut_q;
	wcc_pkg::cmd_t             cmd;
	wcc_pkg::sts_t             sts;
	logic                      reg_hit;

	// Byte addresses 0 to 3 hold cut_height; address 4 and above are outside the register map.
	assign reg_hit = (paddr[2] == wcc_pkg::REG_CUT_HEIGHT);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_q <= wcc_pkg::CUT_W'(wcc_pkg::CUT_RESET);
		end else if (psel && penable && pwrite && reg_hit) begin
			cut_q <= pwdata[wcc_pkg::CUT_W-1:0];
		end
	end

	assign prdata = reg_hit ? 32'(cut_q) : '0;

	// Controller: hold the request side while a start request runs, drive results.
	wcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: store, minimum search, update arithmetic, labels.
	wcc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (req.func),
		.row_index     (req.row_index),
		.col_index     (req.col_index),
		.distance      (req.distance),
		.point_count   (req.point_count),
		.cut_height    (cut_q),
		.point_index   (rsp.point_index),
		.cluster_id    (rsp.cluster_id),
		.cluster_count (rsp.cluster_count),
		.last_point    (rsp.last_point)
	);

endmodule

// ===== test/ward_clustering_cut_tb.sv =====
// Self-checking testbench for the Ward clustering cut block: directed table, then random sets.
`timescale 1ns / 1ps

module ward_clustering_cut_tb;
	import wcc_pkg::*;

	localparam bit FUNC_LOAD  = 1'b0;
	localparam bit FUNC_START = 1'b1;
	localparam logic [2:0] ADDR_CUT    = 3'd0;
	localparam logic [2:0] ADDR_UNUSED = 3'd4;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 310;
	localparam int SETTLE_CYCLES = 20;

	// how a directed row's results are obtained
	typedef enum bit [1:0] {EXP_MODEL, EXP_NONE, EXP_ONE} exp_kind_t;

	typedef struct packed {
		logic              func;
		logic [IDX_W-1:0]  row_index;
		logic [IDX_W-1:0]  col_index;
		logic [DIST_W-1:0] distance;
		logic [CNT_W-1:0]  point_count;
	} request_t;

	typedef struct packed {
		logic [IDX_W-1:0] point_index;
		logic [IDX_W-1:0] cluster_id;
		logic [CNT_W-1:0] cluster_count;
		logic             last_point;
	} assignment_t;

	typedef struct packed {
		exp_kind_t   kind;
		request_t    item;
		assignment_t typed;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	wcc_req_if req();
	wcc_rsp_if rsp();

	ward_clustering_cut dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req), .rsp(rsp)
	);

	// predictor state: its own copy of the store, the merge bookkeeping and the cut register
	bit [SQ_W-1:0]   sq_store [MAX_POINTS*MAX_POINTS];
	bit              loaded [MAX_POINTS*MAX_POINTS];
	bit              active [MAX_POINTS];
	longint          sizes [MAX_POINTS];
	int              labels [MAX_POINTS];
	bit [CUT_W-1:0]  cut_model = CUT_W'(CUT_RESET);

	assignment_t pending_clusters[$];
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int starts_sent = 0;
	int cut_writes = 0;
	int cycles = 0;
	int send_idle = 0;
	int recv_stall = 0;

	always #2 clk = ~clk;

	initial begin
		req.valid = 1'b0;
		req.func = 1'b0;
		req.row_index = '0;
		req.col_index = '0;
		req.distance = '0;
		req.point_count = '0;
		rsp.ready = 1'b0;
	end

	// bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t, %0d results still expected", $time,
				pending_clusters.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: stall at the rate of the current phase
	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= recv_stall);
	end

	// sample results at the falling edge, where every signal is settled for the next rising edge
	always @(negedge clk) begin
		assignment_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			results_seen++;
			if (pending_clusters.size() == 0) begin
				errors++;
				$display("%0t: unexpected result point %0d cluster %0d count %0d last %0b", $time,
					rsp.point_index, rsp.cluster_id, rsp.cluster_count, rsp.last_point);
			end else begin
				want = pending_clusters.pop_front();
				if (rsp.point_index !== want.point_index) begin
					errors++;
					$display("%0t: point_index expected %0d got %0d", $time,
						want.point_index, rsp.point_index);
				end
				if (rsp.cluster_id !== want.cluster_id) begin
					errors++;
					$display("%0t: cluster_id expected %0d got %0d (point %0d)", $time,
						want.cluster_id, rsp.cluster_id, want.point_index);
				end
				if (rsp.cluster_count !== want.cluster_count) begin
					errors++;
					$display("%0t: cluster_count expected %0d got %0d (point %0d)", $time,
						want.cluster_count, rsp.cluster_count, want.point_index);
				end
				if (rsp.last_point !== want.last_point) begin
					errors++;
					$display("%0t: last_point expected %0b got %0b (point %0d)", $time,
						want.last_point, rsp.last_point, want.point_index);
				end
			end
		end
	end

	// square a Q2.16 value into Q16.16, truncate and saturate to 32 bits
	function automatic bit [SQ_W-1:0] square_q(input bit [63:0] v);
		bit [63:0] sq;
		sq = (v * v) >> FRAC_BITS;
		return (sq > 64'hFFFF_FFFF) ? '1 : sq[SQ_W-1:0];
	endfunction

	// predict one request: update the store on a load, run the full merge walk on a start
	task automatic predict_clusters(input request_t it, ref assignment_t res[$]);
		int n, i, j, k, mi, mj, clusters, old_id, new_id, lab;
		bit found;
		bit [SQ_W-1:0] best, h_sq, v;
		bit [63:0] d;
		longint num, q, ni, nj, nk;
		int remap [MAX_POINTS];
		assignment_t r;
		res.delete();
		if (it.func == FUNC_LOAD) begin
			d = 64'(it.distance);
			if (d > 64'(DIST_CLAMP))
				d = 64'(DIST_CLAMP);
			sq_store[it.row_index*MAX_POINTS + it.col_index] = square_q(d);
			sq_store[it.col_index*MAX_POINTS + it.row_index] = square_q(d);
			loaded[it.row_index*MAX_POINTS + it.col_index] = 1'b1;
			loaded[it.col_index*MAX_POINTS + it.row_index] = 1'b1;
			return;
		end
		n = (int'(it.point_count) > MAX_POINTS) ? MAX_POINTS : int'(it.point_count);
		if (n == 0)
			return;
		for (i = 0; i < MAX_POINTS; i++) begin
			active[i] = 1'b1;
			sizes[i] = 1;
			labels[i] = i;
		end
		h_sq = square_q(64'(cut_model));
		while (1) begin
			found = 1'b0;
			best = '0;
			mi = 0;
			mj = 0;
			for (i = 0; i < n; i++) begin
				if (!active[i])
					continue;
				for (j = i + 1; j < n; j++) begin
					if (active[j] && (!found || sq_store[i*MAX_POINTS + j] < best)) begin
						found = 1'b1;
						best = sq_store[i*MAX_POINTS + j];
						mi = i;
						mj = j;
					end
				end
			end
			if (!found || best > h_sq)
				break;
			// Ward update of every other active cluster against the merged pair
			ni = sizes[mi];
			nj = sizes[mj];
			for (k = 0; k < n; k++) begin
				if (!active[k] || k == mi || k == mj)
					continue;
				nk = sizes[k];
				num = (nk + ni) * longint'(sq_store[k*MAX_POINTS + mi])
					+ (nk + nj) * longint'(sq_store[k*MAX_POINTS + mj])
					- nk * longint'(best);
				q = num / (nk + ni + nj);
				if (q < 0)
					v = '0;
				else if (q > 64'sh0_FFFF_FFFF)
					v = '1;
				else
					v = q[SQ_W-1:0];
				sq_store[k*MAX_POINTS + mi] = v;
				sq_store[mi*MAX_POINTS + k] = v;
			end
			old_id = labels[mj];
			new_id = labels[mi];
			for (i = 0; i < n; i++)
				if (labels[i] == old_id)
					labels[i] = new_id;
			sizes[mi] += sizes[mj];
			active[mj] = 1'b0;
		end
		// renumber in order of first appearance
		for (i = 0; i < MAX_POINTS; i++)
			remap[i] = MAX_POINTS;
		clusters = 0;
		for (i = 0; i < n; i++) begin
			lab = labels[i] % MAX_POINTS;
			if (remap[lab] == MAX_POINTS)
				remap[lab] = clusters++;
			labels[i] = remap[lab];
		end
		for (i = 0; i < n; i++) begin
			r.point_index = IDX_W'(i);
			r.cluster_id = IDX_W'(labels[i]);
			r.cluster_count = CNT_W'(clusters);
			r.last_point = (i + 1 == n);
			res = {res, r};
		end
	endtask

	// drive one request and hold it until taken; enter and leave on a rising edge
	task automatic send_request(input request_t it);
		bit took;
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.func <= it.func;
		req.row_index <= it.row_index;
		req.col_index <= it.col_index;
		req.distance <= it.distance;
		req.point_count <= it.point_count;
		do begin
			@(negedge clk);
			took = req.ready;
			@(posedge clk);
		end while (!took);
		items_sent++;
		if (it.func == FUNC_START)
			starts_sent++;
	endtask

	// send a request and queue what the predictor says it causes
	task automatic submit(input request_t it);
		assignment_t got[$];
		send_request(it);
		predict_clusters(it, got);
		foreach (got[i])
			pending_clusters = {pending_clusters, got[i]};
	endtask

	// wait until every expected result is in, then let the block settle
	task automatic drain();
		req.valid <= 1'b0;
		while (pending_clusters.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if ((a >> 2) == REG_CUT_HEIGHT)
			cut_model = d[CUT_W-1:0];
	endtask

	// read the cut register back and compare with the model copy
	task automatic apb_check_cut();
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_CUT;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		got = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== 32'(cut_model)) begin
			errors++;
			$display("%0t: cut_height readback expected %0d got %0d", $time, cut_model, got);
		end
	endtask

	task automatic set_cut(input logic [31:0] value);
		drain();
		apb_write(ADDR_CUT, value);
		apb_check_cut();
		cut_writes++;
	endtask

	function automatic logic [DIST_W-1:0] pick_distance();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return DIST_W'($urandom_range(0, 30000));
			5, 6:          return DIST_W'($urandom_range(0, 262143));
			7:             return '0;
			8:             return DIST_CLAMP;
			default:       return DIST_W'($urandom_range(131073, 262143));
		endcase
	endfunction

	// load every pair of the first n points that is still unwritten, refresh others at random,
	// then start with the given count field
	task automatic cluster_set(input int n, input int count_field, input int refresh_pct);
		request_t it;
		int i, j, loads;
		loads = 0;
		for (i = 0; i < n; i++)
			for (j = i + 1; j < n; j++)
				if (!loaded[i*MAX_POINTS + j] || $urandom_range(99) < refresh_pct) begin
					it = '0;
					it.func = FUNC_LOAD;
					if ($urandom_range(1)) begin
						it.row_index = IDX_W'(i);
						it.col_index = IDX_W'(j);
					end else begin
						it.row_index = IDX_W'(j);
						it.col_index = IDX_W'(i);
					end
					it.distance = pick_distance();
					it.point_count = CNT_W'($urandom_range(0, 127));
					submit(it);
					loads++;
				end
		it = '0;
		it.func = FUNC_START;
		it.row_index = IDX_W'($urandom_range(0, 63));
		it.col_index = IDX_W'($urandom_range(0, 63));
		it.distance = DIST_W'($urandom_range(0, 262143));
		it.point_count = CNT_W'(count_field);
		submit(it);
	endtask

	task automatic pick_idle_phase(input int ph);
		case (ph % 4)
			0: begin send_idle = 0;  recv_stall = 0;  end
			1: begin send_idle = 53; recv_stall = 0;  end
			2: begin send_idle = 0;  recv_stall = 53; end
			default: begin send_idle = 36; recv_stall = 36; end
		endcase
	endtask

	// directed table: reset cut height, so the squared cut is 5898 (about 0.09)
	dir_row_t dir_rows [] = '{
		'{EXP_NONE,  '{FUNC_START, 6'd0,  6'd0,  18'd0,      7'd0}, '0},
		'{EXP_ONE,   '{FUNC_START, 6'd0,  6'd0,  18'd0,      7'd1}, '{6'd0, 6'd0, 7'd1, 1'b1}},
		'{EXP_NONE,  '{FUNC_LOAD,  6'd0,  6'd1,  18'd0,      7'd0}, '0},
		'{EXP_NONE,  '{FUNC_LOAD,  6'd1,  6'd0,  18'h3FFFF,  7'd0}, '0},
		'{EXP_MODEL, '{FUNC_START, 6'd0,  6'd0,  18'd0,      7'd2}, '0},
		'{EXP_NONE,  '{FUNC_LOAD,  6'd0,  6'd1,  18'd0,      7'd127}, '0},
		'{EXP_MODEL, '{FUNC_START, 6'd63, 6'd63, 18'h3FFFF,  7'd2}, '0},
		'{EXP_NONE,  '{FUNC_LOAD,  6'd0,  6'd2,  18'd131072, 7'd0}, '0},
		'{EXP_NONE,  '{FUNC_LOAD,  6'd2,  6'd1,  18'd1000,   7'd0}, '0},
		'{EXP_NONE,  '{FUNC_LOAD,  6'd0,  6'd1,  18'd3000,   7'd0}, '0},
		'{EXP_MODEL, '{FUNC_START, 6'd0,  6'd0,  18'd0,      7'd3}, '0},
		'{EXP_MODEL, '{FUNC_START, 6'd0,  6'd0,  18'd0,      7'd3}, '0},
		'{EXP_NONE,  '{FUNC_LOAD,  6'd0,  6'd1,  18'd1000,   7'd0}, '0},
		'{EXP_NONE,  '{FUNC_LOAD,  6'd0,  6'd2,  18'd1000,   7'd0}, '0},
		'{EXP_NONE,  '{FUNC_LOAD,  6'd1,  6'd2,  18'd1000,   7'd0}, '0},
		'{EXP_MODEL, '{FUNC_START, 6'd0,  6'd0,  18'd0,      7'd3}, '0},
		'{EXP_NONE,  '{FUNC_LOAD,  6'd63, 6'd62, 18'h3FFFF,  7'd64}, '0},
		'{EXP_NONE,  '{FUNC_LOAD,  6'd63, 6'd63, 18'd0,      7'd0}, '0},
		'{EXP_NONE,  '{FUNC_LOAD,  6'd3,  6'd0,  18'd5000,   7'd0}, '0},
		'{EXP_NONE,  '{FUNC_LOAD,  6'd1,  6'd3,  18'd131071, 7'd0}, '0},
		'{EXP_NONE,  '{FUNC_LOAD,  6'd3,  6'd2,  18'd77,     7'd0}, '0},
		'{EXP_MODEL, '{FUNC_START, 6'd0,  6'd0,  18'd0,      7'd4}, '0}
	};

	initial begin
		assignment_t got[$];
		int seq, ph, n, r;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register after reset, then a write to an unused index must leave it alone
		apb_check_cut();
		apb_write(ADDR_UNUSED, 32'h0001_2345);
		apb_check_cut();

		// walk the directed table with no idling
		foreach (dir_rows[i]) begin
			send_request(dir_rows[i].item);
			predict_clusters(dir_rows[i].item, got);
			case (dir_rows[i].kind)
				EXP_MODEL: foreach (got[j]) pending_clusters = {pending_clusters, got[j]};
				EXP_ONE:   pending_clusters = {pending_clusters, dir_rows[i].typed};
				default:   ;
			endcase
		end

		// random part: mostly complete sets with random content, some noise loads
		seq = 0;
		ph = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (seq % 4 == 0) begin
				case ((seq / 4) % 5)
					0: set_cut(32'd131072);
					1: set_cut(32'(CUT_RESET));
					2: set_cut(32'd0);
					3: set_cut($urandom_range(0, 131072));
					default: set_cut($urandom());
				endcase
				pick_idle_phase(ph++);
			end
			r = $urandom_range(99);
			if (r < 10)
				n = $urandom_range(0, 1);
			else if (r < 88)
				n = $urandom_range(2, 8);
			else
				n = $urandom_range(9, 14);
			// noise loads anywhere in the store
			repeat ($urandom_range(0, 3))
				submit('{FUNC_LOAD, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
					pick_distance(), 7'($urandom_range(0, 127))});
			cluster_set(n, n, 30);
			seq++;
		end

		drain();
		$display("covered %0d requests (%0d starts) and %0d results over %0d cut settings",
			items_sent, starts_sent, results_seen, cut_writes + 1);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
design/wcc_pkg.sv
design/wcc_req_if.sv
design/wcc_rsp_if.sv
design/wcc_ram.sv
design/wcc_ctrl.sv
design/wcc_dp.sv
design/ward_clustering_cut.sv
test/ward_clustering_cut_tb.sv
